/* hdl/assert_macros.svh */
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("port checker: implication failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("port checker: next-cycle implication failed");

`endif

/* hdl/mpm_pkg.sv */
`default_nettype none

package mpm_pkg;

  localparam int MAX_SIDE_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 26;
  localparam int INT_BITS      = 6;

  localparam int SIDE_REG_W = 13;
  localparam int ITER_W     = 16;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [SIDE_REG_W-1:0] WIDTH_RST  = 13'd960;
  localparam logic [SIDE_REG_W-1:0] HEIGHT_RST = 13'd640;
  localparam logic [ITER_W-1:0]     ITER_RST   = 16'd256;

endpackage

`default_nettype wire

/* hdl/mpm_frac_div.sv */
`default_nettype none

// Restoring divider: quo = floor(num * 2^FRAC_BITS / den), num < 3*den.
// Two integer steps then FRAC_BITS fraction steps, one bit per cycle.
module mpm_frac_div #(
  parameter int SW        = 13,
  parameter int FRAC_BITS = 26
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [SW+1:0]        num_i,
  input  wire logic [SW-1:0]        den_i,
  output logic                      done_o,
  output logic [FRAC_BITS+1:0]      quo_o
);

  localparam int CNTW = $clog2(FRAC_BITS + 2);

  logic [SW+1:0]        rem_q;
  logic [SW:0]          dd_q;
  logic [FRAC_BITS+1:0] quo_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 run_q, done_q;

  logic          ge;
  logic [SW+1:0] rem_sub;

  assign ge      = rem_q >= {1'b0, dd_q};
  assign rem_sub = ge ? (rem_q - {1'b0, dd_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(FRAC_BITS + 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dd_q  <= {den_i, 1'b0};
      quo_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[FRAC_BITS:0], ge};
      if (cnt_q == '0) begin
        // first integer bit compared against 2*den; drop to den after
        rem_q <= rem_sub;
        dd_q  <= {1'b0, dd_q[SW:1]};
      end else begin
        rem_q <= {rem_sub[SW:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* hdl/mandelbrot_pixel_membership_core.sv */
`default_nettype none

// Mandelbrot escape-time test for one pixel. Pulse start with the pixel's
// column and row while busy is low; the beat is taken on that edge and busy
// rises. The column maps to c.re = -2 + 3*col/width and the row to
// c.im = -1 + 2*row/height (out-of-range coordinates clamp to the last
// column/row; a zero side counts as 1, a side above MAX_SIDE as MAX_SIDE).
// z = z^2 + c is then run from z = 0 up to max_iterations times in signed
// fixed point with FRAC_BITS fraction bits. The result beat shows on
// in_set_o for exactly one cycle with done_o high, in the same cycle busy
// drops; the receiver cannot stall it, so sample it when done_o is seen.
// in_set_o = 0 means the point escaped (|z|^2 > 4), 1 means it never did.
// Two mapping divisions run one after the other on the one-bit-per-cycle
// divider; then each iteration steps through the update, a^2, b^2 and
// a*b with the escape test, the products coming from the single shared
// multiplier, and the result is reported through a registered done_o.
// Configuration writes are taken any time but belong in idle periods.
module mandelbrot_pixel_membership_core #(
  parameter int MAX_SIDE  = mpm_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = mpm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [mpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // command beat
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mpm_pkg::COORD_W-1:0]     pixel_column_i,
  input  wire logic [mpm_pkg::COORD_W-1:0]     pixel_row_i,
  // result beat
  output logic                                 done_o,
  output logic                                 in_set_o
);

  import mpm_pkg::*;

  localparam int W  = FRAC_BITS + INT_BITS;  // signed value width
  localparam int MW = FRAC_BITS + 3;         // magnitude width, |a|,|b| < 8
  localparam int SW = $clog2(MAX_SIDE + 1);  // effective side width

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVR = 3'd1;  // real-part division running
  localparam logic [2:0] S_DIVI = 3'd2;  // imaginary-part division running
  localparam logic [2:0] S_UPD  = 3'd3;  // z = z^2 + c from sa, sb, ab
  localparam logic [2:0] S_SQA  = 3'd4;  // multiply a*a
  localparam logic [2:0] S_SQB  = 3'd5;  // multiply b*b
  localparam logic [2:0] S_TST  = 3'd6;  // escape test, multiply a*b

  localparam logic [W:0] FOUR = (W + 1)'(4) << FRAC_BITS;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIDE_REG_W-1:0] width_q, height_q;
  logic [ITER_W-1:0]     max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      max_iter_q <= ITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:    width_q    <= cfg_wdata_i[SIDE_REG_W-1:0];
        REG_IMAGE_HEIGHT:   height_q   <= cfg_wdata_i[SIDE_REG_W-1:0];
        REG_MAX_ITERATIONS: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Effective sides: zero reads as 1, oversize clamps to MAX_SIDE
  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_q) > 32'(MAX_SIDE)) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_q) > 32'(MAX_SIDE)) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(height_q);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  logic [2:0] state_q, state_d;
  logic       done_q, done_d;
  logic       in_set_q, in_set_d;
  logic       accept;

  assign accept = start && (state_q == S_IDLE);

  // ---------------------------------------------------------------------
  // Pixel mapping: one divider, real part first, then imaginary
  // ---------------------------------------------------------------------
  logic [COORD_W-1:0]   row_q;
  logic                 sel_re;
  logic [COORD_W-1:0]   coord;
  logic [SW-1:0]        den_sel, coord_c;
  logic [SW+1:0]        div_num;
  logic                 div_start, div_done;
  logic [FRAC_BITS+1:0] div_quo;

  assign sel_re  = (state_q == S_IDLE);
  assign coord   = sel_re ? pixel_column_i : row_q;
  assign den_sel = sel_re ? w_eff : h_eff;

  always_comb begin
    if (32'(coord) >= 32'(den_sel)) begin
      coord_c = den_sel - 1'b1;
    end else begin
      coord_c = SW'(coord);
    end
  end

  // 3*col for the real part, 2*row for the imaginary part
  assign div_num   = sel_re ? ({2'b00, coord_c} + {1'b0, coord_c, 1'b0})
                            : {1'b0, coord_c, 1'b0};
  assign div_start = accept || ((state_q == S_DIVR) && div_done);

  mpm_frac_div #(
    .SW        (SW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_sel),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------
  // Iteration datapath around one shared multiplier
  // ---------------------------------------------------------------------
  logic [W-1:0]      cre_q, cim_q;   // signed c
  logic [W-1:0]      a_q, b_q;       // signed z
  logic [W-1:0]      sa_q, sb_q;     // a^2, b^2 (unsigned, floored)
  logic [2*MW-1:0]   prod_q, prod_d;
  logic [ITER_W-1:0] cnt_q;

  logic [W-1:0]    a_abs_w, b_abs_w;
  logic [MW-1:0]   ma, mb, mul_x, mul_y;
  logic [W-1:0]    sq_new, ab_mag, ab_sgn;
  logic [W:0]      a_ext, esc_sum;
  logic            escaped;
  logic [W-1:0]    quo_ext;

  assign a_abs_w = a_q[W-1] ? (~a_q + 1'b1) : a_q;
  assign b_abs_w = b_q[W-1] ? (~b_q + 1'b1) : b_q;
  assign ma      = a_abs_w[MW-1:0];
  assign mb      = b_abs_w[MW-1:0];

  always_comb begin
    case (state_q)
      S_SQA: begin
        mul_x = ma;
        mul_y = ma;
      end
      S_SQB: begin
        mul_x = mb;
        mul_y = mb;
      end
      default: begin
        mul_x = ma;
        mul_y = mb;
      end
    endcase
  end

  assign prod_d = (2*MW)'(mul_x) * (2*MW)'(mul_y);

  // square of a magnitude, floored to FRAC_BITS
  assign sq_new = prod_q[FRAC_BITS +: W];
  // 2*|a|*|b| floored, then signed: rounds toward zero
  assign ab_mag = prod_q[FRAC_BITS-1 +: W];
  assign ab_sgn = (a_q[W-1] ^ b_q[W-1]) ? (~ab_mag + 1'b1) : ab_mag;

  assign a_ext   = {1'b0, sa_q} - {1'b0, sb_q} + {cre_q[W-1], cre_q};
  assign esc_sum = {1'b0, sa_q} + {1'b0, sq_new};
  assign escaped = esc_sum > FOUR;
  assign quo_ext = W'(div_quo);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    in_set_d = in_set_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_done) begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        if (div_done) begin
          if (max_iter_q == '0) begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            in_set_d = 1'b1;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_UPD: state_d = S_SQA;
      S_SQA: state_d = S_SQB;
      S_SQB: state_d = S_TST;
      S_TST: begin
        if (escaped) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          in_set_d = 1'b0;
        end else if (cnt_q == max_iter_q) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          in_set_d = 1'b1;
        end else begin
          state_d = S_UPD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_set_q <= in_set_d;
    if (accept) begin
      row_q <= pixel_row_i;
    end
    if ((state_q == S_DIVR) && div_done) begin
      cre_q <= quo_ext - (ONE << 1);
    end
    if ((state_q == S_DIVI) && div_done) begin
      // z = 0, so a^2 = b^2 = a*b = 0 going into the first update
      cim_q  <= quo_ext - ONE;
      a_q    <= '0;
      b_q    <= '0;
      sa_q   <= '0;
      sb_q   <= '0;
      prod_q <= '0;
      cnt_q  <= '0;
    end
    case (state_q)
      S_UPD: begin
        a_q   <= a_ext[W-1:0];
        b_q   <= ab_sgn + cim_q;
        cnt_q <= cnt_q + 1'b1;
      end
      S_SQA: prod_q <= prod_d;
      S_SQB: begin
        sa_q   <= sq_new;
        prod_q <= prod_d;
      end
      S_TST: begin
        sb_q   <= sq_new;
        prod_q <= prod_d;
      end
      default: ;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign in_set_o = in_set_q;

endmodule

`default_nettype wire

/* hdl/mpm_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module mpm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  // a result beat only appears once the block is free again
  `ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_o, !busy)

  // an accepted beat makes the block busy
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // busy drops only together with a result beat
  `ASSERT_IMPL(a_fall_done, clk_i, rst_ni, $fell(busy), done_o)

  // each result beat is a single-cycle strobe
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

bind mandelbrot_pixel_membership_core mpm_checker u_mpm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

`default_nettype wire

/* tb/mandelbrot_pixel_membership_checker.sv */
`timescale 1ns / 100ps

// Watches the config, command and result channels of the membership core.
// Keeps its own copy of the registers, predicts in_set for every accepted
// command beat and compares each result beat with the oldest prediction.
module mandelbrot_pixel_membership_checker
  import mpm_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [COORD_W-1:0]    pixel_column_i,
  input  logic [COORD_W-1:0]    pixel_row_i,
  input  logic                  done_i,
  input  logic                  in_set_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    inside_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               in_set;
  } membership_t;

  localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
  localparam u64_t   FOUR_Q = u64_t'(4) << FRAC_BITS;

  logic [SIDE_REG_W-1:0] width_q;
  logic [SIDE_REG_W-1:0] height_q;
  logic [ITER_W-1:0]     iter_limit_q;
  membership_t           membership_q[$];

  // Zero counts as one, oversized sides clamp.
  function automatic u64_t span(logic [SIDE_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_SIDE) return u64_t'(MAX_SIDE);
    return u64_t'(r);
  endfunction

  function automatic u64_t mag(longint v);
    return (v < 0) ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Full product, shifted right, low 64 bits kept (floor).
  function automatic u64_t fixmul(u64_t p, u64_t q, int sh);
    logic [127:0] full;
    full = {64'd0, p} * {64'd0, q};
    return full[sh +: 64];
  endfunction

  function automatic logic predict_in_set(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    u64_t        w, h, cx, cy, ma, mb, sa, sb;
    longint      cre, cim, a, b, ab;
    int unsigned n;
    w  = span(width_q);
    h  = span(height_q);
    cx = (u64_t'(col) >= w) ? w - 1 : u64_t'(col);
    cy = (u64_t'(row) >= h) ? h - 1 : u64_t'(row);
    cre = $signed(((3 * cx) << FRAC_BITS) / w) - 2 * ONE_Q;
    cim = $signed(((2 * cy) << FRAC_BITS) / h) - ONE_Q;
    a = 0;
    b = 0;
    for (n = 0; n < iter_limit_q; n++) begin
      ma = mag(a);
      mb = mag(b);
      sa = fixmul(ma, ma, FRAC_BITS);
      sb = fixmul(mb, mb, FRAC_BITS);
      // 2ab from magnitudes, so it rounds toward zero
      ab = $signed(fixmul(ma, mb, FRAC_BITS - 1));
      if ((a < 0) != (b < 0)) ab = -ab;
      a = $signed(sa) - $signed(sb) + cre;
      b = ab + cim;
      ma = mag(a);
      mb = mag(b);
      if (fixmul(ma, ma, FRAC_BITS) + fixmul(mb, mb, FRAC_BITS) > FOUR_Q) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    membership_t head;
    if (!rst_ni) begin
      width_q      = WIDTH_RST;
      height_q     = HEIGHT_RST;
      iter_limit_q = ITER_RST;
      membership_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
      inside_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:    width_q      = cfg_wdata_i[SIDE_REG_W-1:0];
          REG_IMAGE_HEIGHT:   height_q     = cfg_wdata_i[SIDE_REG_W-1:0];
          REG_MAX_ITERATIONS: iter_limit_q = cfg_wdata_i[ITER_W-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        results_o++;
        if (in_set_i === 1'b1) inside_o++;
        if (membership_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("result beat with nothing pending: in_set=%0b", in_set_i);
        end else begin
          head = membership_q.pop_front();
          if (in_set_i !== head.in_set) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("pixel (%0d,%0d): in_set expected %0b, got %0b",
                       head.col, head.row, head.in_set, in_set_i);
          end
        end
      end
      if (start_i && busy_i === 1'b0)
        membership_q.push_back('{pixel_column_i, pixel_row_i,
                                 predict_in_set(pixel_column_i, pixel_row_i)});
      pending_o = membership_q.size();
    end
  end

endmodule

/* tb/tb_mandelbrot_pixel_membership_core.sv */
`timescale 1ns / 100ps

// Top of the membership core bench: clock, reset, config writes, command
// beats and the verdict. All prediction and comparison lives in the checker.
module tb_mandelbrot_pixel_membership_core;
  import mpm_pkg::*;

  // Index with no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Longest silent stretch of a good run is one pixel inside the set at an
  // iteration limit of 65535.
  localparam int unsigned QUIET_LIMIT = 1_000_000;
  // Settling time after the last result before the verdict.
  localparam int unsigned TAIL_CYCLES = 2 * FRAC_BITS_DEF + 16;
  localparam int          PHASES      = 12;
  localparam int          PHASE_BEATS = 150;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [COORD_W-1:0]    pixel_column_i = '0;
  logic [COORD_W-1:0]    pixel_row_i    = '0;
  logic                  done_o;
  logic                  in_set_o;

  int          mismatches;
  int          pending;
  int          results;
  int          in_set_hits;
  int          pixels_sent  = 0;
  int          settings_run = 1;   // reset values count as the first
  bit          burst        = 1'b0;
  int unsigned quiet_cycles = 0;

  mandelbrot_pixel_membership_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .done_o         (done_o),
    .in_set_o       (in_set_o)
  );

  mandelbrot_pixel_membership_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start),
    .busy_i         (busy),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .done_i         (done_o),
    .in_set_i       (in_set_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .results_o      (results),
    .inside_o       (in_set_hits)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: cycles with neither a command beat nor a result beat.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[mandelbrot_pixel_membership_core] ERROR");
      $finish;
    end
  end

  // One register write per edge; the caller drops cfg_we_i after the last.
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all three registers plus the unmapped index. Bits above the
  // register width carry random junk that the core must drop.
  task automatic apply_setting(int unsigned w, int unsigned h, int unsigned iters);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[SIDE_REG_W-1:0] = w[SIDE_REG_W-1:0];
    reg_write(REG_IMAGE_WIDTH, d);
    d = CFG_DATA_W'($urandom);
    d[SIDE_REG_W-1:0] = h[SIDE_REG_W-1:0];
    reg_write(REG_IMAGE_HEIGHT, d);
    reg_write(REG_MAX_ITERATIONS, iters[ITER_W-1:0]);
    reg_write(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Issues one command beat after a random gap (none in burst phases).
  // start is left high after the beat is taken; the next call either lowers
  // it for a gap or loads the next pixel in the same step.
  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    do @(posedge clk_i); while (busy !== 1'b0);
    pixels_sent++;
  endtask

  // Stop issuing and wait until every predicted result has come back.
  // The first edge makes sure the checker has logged the last beat.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy !== 1'b0);
  endtask

  // Side register value for a random phase: mostly legal, sometimes zero,
  // oversized or tiny.
  function automatic int unsigned pick_side();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return $urandom_range(MAX_SIDE_DEF + 1, 8191);
      2:       return $urandom_range(1, 8);
      default: return $urandom_range(9, MAX_SIDE_DEF);
    endcase
  endfunction

  initial begin
    int unsigned w, h, iters, col_span, row_span;
    logic [COORD_W-1:0] col, row;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed: reset values 960 x 640, 256 iterations ----
    send_pixel(12'd0, 12'd0);       // c = -2 - i, escapes on the first step
    send_pixel(12'd640, 12'd320);   // c = 0, fixed point at the origin
    send_pixel(12'd720, 12'd320);   // c = 0.25, cusp of the main cardioid
    send_pixel(12'd480, 12'd480);   // c = -0.5 + 0.5i, inside
    send_pixel(12'd959, 12'd639);   // last legal pixel
    send_pixel(12'd960, 12'd640);   // one past the end, clamps to the last
    send_pixel(12'd4095, 12'd4095); // all ones, clamps as well

    // ---- Zero sides count as one; zero iterations always answers inside ----
    drain();
    apply_setting(0, 0, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // ---- Oversized sides clamp to MAX_SIDE; a single iteration ----
    drain();
    apply_setting(8191, 8191, 1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd4095, 12'd4095);

    // ---- c = -2 sits exactly on |z|^2 = 4, which must not count as escape ----
    drain();
    apply_setting(3, 2, 64);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd1, 12'd1);       // c = -1, period-two orbit

    // ---- Full iteration limit: one long inside point, two fast escapes ----
    drain();
    apply_setting(3, 2, 65535);
    send_pixel(12'd2, 12'd1);       // c = 0, runs all 65535 iterations
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);       // c = -1 - i, escapes on the third step

    // ---- Random phases: new setting each time, mostly in-range pixels ----
    // Only one phase runs long limits so the cycle count stays bounded.
    for (int phase = 0; phase < PHASES; phase++) begin
      w = pick_side();
      h = pick_side();
      if (phase == 5) begin
        iters = $urandom_range(200, 256);
      end else if ($urandom_range(0, 7) == 0) begin
        iters = 0;
      end else begin
        iters = $urandom_range(1, 48);
      end
      col_span = (w == 0) ? 1 : (w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : w;
      row_span = (h == 0) ? 1 : (h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : h;
      burst = ($urandom_range(0, 3) == 0);
      drain();
      apply_setting(w, h, iters);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // mid-phase hold-off until everything in flight has returned
        if (k == PHASE_BEATS / 2) drain();
        if ($urandom_range(0, 9) == 0) begin
          col = COORD_W'($urandom_range(0, 4095));
          row = COORD_W'($urandom_range(0, 4095));
        end else begin
          col = COORD_W'($urandom_range(0, col_span - 1));
          row = COORD_W'($urandom_range(0, row_span - 1));
        end
        send_pixel(col, row);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d pixels over %0d register settings (sides 0..8191, limits 0..65535).",
             pixels_sent, settings_run);
    $display("Results: %0d inside the set, %0d escaped, %0d mismatches.",
             in_set_hits, results - in_set_hits, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[mandelbrot_pixel_membership_core] OK");
    end else begin
      $display("[mandelbrot_pixel_membership_core] ERROR");
    end
    $finish;
  end

endmodule
